### hdl/polyline_area_simplifier_assert.svh
// Assertion macros shared by the polyline area simplifier modules.
`ifndef POLYLINE_AREA_SIMPLIFIER_ASSERT_SVH
`define POLYLINE_AREA_SIMPLIFIER_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define PAS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A consequence that must hold in the cycle after its trigger.
`define PAS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/pas_pkg.sv
// Shared types and constants of the polyline area simplifier.
package pas_pkg;

  localparam int CNT_W = 7;
  localparam int IDX_OUT_W = 6;
  localparam int THR_W = 33;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             ovf;
  } run_cmd_t;

  typedef enum logic [5:0] {
    BK_IDLE, BK_INIT, BK_PUSH,
    BK_TRI0, BK_TRI1, BK_TRI2, BK_TRI3, BK_TRI4, BK_TRI5,
    BK_SU0, BK_SU1, BK_SU2, BK_SUEND,
    BK_SD0, BK_SD1, BK_SD2, BK_SD3, BK_SD4, BK_SD5, BK_SDEND,
    BK_POP0, BK_POP1, BK_POP2, BK_POP3,
    BK_CHK0, BK_CHK1, BK_CHK2, BK_CHK3, BK_CHK4, BK_NXT,
    BK_UPD0, BK_UPD1, BK_EMIT, BK_DONE
  } back_state_t;

  typedef enum logic [1:0] {
    TR_INIT, TR_PREV, TR_NEXT
  } tri_ret_t;

  typedef enum logic [1:0] {
    SR_PUSH, SR_POP, SR_PREV, SR_NEXT
  } sift_ret_t;

endpackage

### hdl/pas_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pas_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/pas_cmd_fifo.sv
// Two-entry queue of run commands between the loader and the simplifier.
module pas_cmd_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_valid,
  input  pas_pkg::run_cmd_t wr_data,
  output logic              rd_valid,
  input  logic              rd_ready,
  output pas_pkg::run_cmd_t rd_data
);

  pas_pkg::run_cmd_t entry [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] fill;
  logic       push;
  logic       pop;

  assign push = wr_valid && (fill != 2'd2);
  assign pop = rd_valid && rd_ready;
  assign rd_valid = (fill != 2'd0);
  assign rd_data = entry[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wptr] <= wr_data;
    end
  end

endmodule

### hdl/pas_front.sv
// Point loader: stores incoming points and issues a run command on the final one.
`include "polyline_area_simplifier_assert.svh"

module pas_front #(
  parameter int MAX_POINTS = 64,
  parameter int COORD_BITS = 16,
  localparam int IDX_W = $clog2(MAX_POINTS),
  localparam int DW = ((2 * COORD_BITS + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [DW-1:0]         s_tdata,
  input  logic                  s_tlast,
  output logic                  wr_en,
  output logic [IDX_W-1:0]      wr_addr,
  output logic [COORD_BITS-1:0] wr_x,
  output logic [COORD_BITS-1:0] wr_y,
  output logic                  cmd_valid,
  output pas_pkg::run_cmd_t     cmd,
  input  logic                  run_done
);

  logic [pas_pkg::CNT_W-1:0] count;
  logic [pas_pkg::CNT_W-1:0] count_next;
  logic                      ovf;
  logic                      ovf_next;
  logic                      lock;
  logic                      accept;
  logic                      room;

  assign s_tready = !lock;
  assign accept = s_tvalid && s_tready;
  assign room = (count < pas_pkg::CNT_W'(MAX_POINTS));

  assign wr_en = accept && room;
  assign wr_addr = count[IDX_W-1:0];
  assign wr_x = s_tdata[COORD_BITS-1:0];
  assign wr_y = s_tdata[2*COORD_BITS-1:COORD_BITS];

  assign count_next = room ? count + pas_pkg::CNT_W'(1) : count;
  assign ovf_next = ovf || !room;

  assign cmd_valid = accept && s_tlast;
  assign cmd.count = count_next;
  assign cmd.ovf = ovf_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ovf <= 1'b0;
      lock <= 1'b0;
    end else begin
      if (accept) begin
        if (s_tlast) begin
          count <= '0;
          ovf <= 1'b0;
          lock <= 1'b1;
        end else begin
          count <= count_next;
          ovf <= ovf_next;
        end
      end else if (run_done) begin
        lock <= 1'b0;
      end
    end
  end

  // The store is never written while a run is outstanding.
  `PAS_ASSERT_NEXT(a_lock_on_last, cmd_valid, lock && !s_tready, "final point did not lock the loader")
  `PAS_ASSERT(a_no_write_locked, !(lock && wr_en), "store written during a run")

endmodule

### hdl/pas_area.sv
// Pipelined doubled triangle area unit; the cross products and then the area magnitude are registered.
module pas_area #(
  parameter int COORD_BITS = 16,
  localparam int AW = 2 * COORD_BITS + 2
) (
  input  logic                  clk,
  input  logic [COORD_BITS-1:0] xa,
  input  logic [COORD_BITS-1:0] ya,
  input  logic [COORD_BITS-1:0] xb,
  input  logic [COORD_BITS-1:0] yb,
  input  logic [COORD_BITS-1:0] xc,
  input  logic [COORD_BITS-1:0] yc,
  output logic [AW-1:0]         area
);

  localparam int D = COORD_BITS + 1;

  logic signed [D-1:0]  dx1;
  logic signed [D-1:0]  dy1;
  logic signed [D-1:0]  dx2;
  logic signed [D-1:0]  dy2;
  logic signed [AW-1:0] p1;
  logic signed [AW-1:0] p2;
  logic signed [AW:0]   diff;
  logic [AW:0]          mag;

  assign dx1 = {xb[COORD_BITS-1], xb} - {xa[COORD_BITS-1], xa};
  assign dy1 = {yb[COORD_BITS-1], yb} - {ya[COORD_BITS-1], ya};
  assign dx2 = {xc[COORD_BITS-1], xc} - {xa[COORD_BITS-1], xa};
  assign dy2 = {yc[COORD_BITS-1], yc} - {ya[COORD_BITS-1], ya};

  assign diff = {p1[AW-1], p1} - {p2[AW-1], p2};
  assign mag = diff[AW] ? -diff : diff;

  always_ff @(posedge clk) begin
    p1 <= dx1 * dy2;
    p2 <= dy1 * dx2;
    area <= mag[AW-1:0];
  end

endmodule

### hdl/pas_back.sv
// Simplifier engine: builds the area heap, removes points and emits keep flags.
`include "polyline_area_simplifier_assert.svh"

module pas_back #(
  parameter int MAX_POINTS = 64,
  parameter int COORD_BITS = 16,
  localparam int IDX_W = $clog2(MAX_POINTS)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [pas_pkg::THR_W-1:0]    thr,
  input  logic                         cmd_valid,
  output logic                         cmd_ready,
  input  pas_pkg::run_cmd_t            cmd,
  output logic                         run_done,
  output logic [IDX_W-1:0]             xy_raddr,
  input  logic [COORD_BITS-1:0]        x_rd,
  input  logic [COORD_BITS-1:0]        y_rd,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [7:0]                   m_tdata,
  output logic [2:0]                   m_tuser,
  output logic                         m_tlast
);

  localparam int LNK_W = IDX_W + 1;
  localparam int AW = 2 * COORD_BITS + 2;
  localparam int CW = pas_pkg::CNT_W;
  localparam int CHW = IDX_W + 2;
  localparam int CMPW = (AW > pas_pkg::THR_W) ? AW : pas_pkg::THR_W;
  localparam logic [LNK_W-1:0] LINK_NIL = {1'b1, {IDX_W{1'b0}}};

  pas_pkg::back_state_t state;
  pas_pkg::back_state_t state_next;
  pas_pkg::tri_ret_t    tri_ret;
  pas_pkg::sift_ret_t   sift_ret;

  logic [CW-1:0]         n_r;
  logic                  ovf_r;
  logic                  plain_r;
  logic [CW-1:0]         i_r;
  logic [CW-1:0]         hcount;
  logic [CW-1:0]         k_r;
  logic [IDX_W-1:0]      cur;
  logic [IDX_W-1:0]      pv;
  logic [IDX_W-1:0]      nx;
  logic [LNK_W-1:0]      nnx;
  logic [AW-1:0]         acur;
  logic [IDX_W-1:0]      obj;
  logic [AW-1:0]         aobj;
  logic [IDX_W-1:0]      hi;
  logic [IDX_W-1:0]      slot_r;
  logic [IDX_W-1:0]      dpick;
  logic [IDX_W-1:0]      cpick;
  logic [AW-1:0]         apick;
  logic [IDX_W-1:0]      ta;
  logic [IDX_W-1:0]      tb;
  logic [IDX_W-1:0]      tc;
  logic [IDX_W-1:0]      upd_pt;
  logic [AW-1:0]         new_area;
  logic [COORD_BITS-1:0] xa_r;
  logic [COORD_BITS-1:0] ya_r;
  logic [COORD_BITS-1:0] xb_r;
  logic [COORD_BITS-1:0] yb_r;
  logic [MAX_POINTS-1:0] gone;

  logic [AW-1:0]    tri_area;
  logic [AW-1:0]    tri_max;
  logic [IDX_W-1:0] par_idx;
  logic [CHW-1:0]   lch;
  logic [CHW-1:0]   rch;
  logic             l_ok;
  logic             r_ok;
  logic             end_pt;
  logic             out_load;
  logic             last_k;

  logic             a_we;
  logic [IDX_W-1:0] a_waddr;
  logic [AW-1:0]    a_wdata;
  logic [IDX_W-1:0] a_raddr;
  logic [AW-1:0]    a_rd;
  logic             hs_we;
  logic [IDX_W-1:0] hs_waddr;
  logic [IDX_W-1:0] hs_wdata;
  logic [IDX_W-1:0] hs_raddr;
  logic [IDX_W-1:0] hs_rd;
  logic             hp_we;
  logic [IDX_W-1:0] hp_waddr;
  logic [IDX_W-1:0] hp_wdata;
  logic [IDX_W-1:0] hp_raddr;
  logic [IDX_W-1:0] hp_rd;
  logic             pr_we;
  logic [IDX_W-1:0] pr_waddr;
  logic [LNK_W-1:0] pr_wdata;
  logic [IDX_W-1:0] pr_raddr;
  logic [LNK_W-1:0] pr_rd;
  logic             nl_we;
  logic [IDX_W-1:0] nl_waddr;
  logic [LNK_W-1:0] nl_wdata;
  logic [IDX_W-1:0] nl_raddr;
  logic [LNK_W-1:0] nl_rd;

  pas_ram #(.WIDTH(AW), .DEPTH(MAX_POINTS)) u_area_ram (
    .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata), .raddr(a_raddr), .rdata(a_rd)
  );
  pas_ram #(.WIDTH(IDX_W), .DEPTH(MAX_POINTS)) u_slot_ram (
    .clk(clk), .we(hs_we), .waddr(hs_waddr), .wdata(hs_wdata), .raddr(hs_raddr), .rdata(hs_rd)
  );
  pas_ram #(.WIDTH(IDX_W), .DEPTH(MAX_POINTS)) u_pos_ram (
    .clk(clk), .we(hp_we), .waddr(hp_waddr), .wdata(hp_wdata), .raddr(hp_raddr), .rdata(hp_rd)
  );
  pas_ram #(.WIDTH(LNK_W), .DEPTH(MAX_POINTS)) u_prev_ram (
    .clk(clk), .we(pr_we), .waddr(pr_waddr), .wdata(pr_wdata), .raddr(pr_raddr), .rdata(pr_rd)
  );
  pas_ram #(.WIDTH(LNK_W), .DEPTH(MAX_POINTS)) u_next_ram (
    .clk(clk), .we(nl_we), .waddr(nl_waddr), .wdata(nl_wdata), .raddr(nl_raddr), .rdata(nl_rd)
  );

  // Coordinates of the third corner go straight from the store into the unit.
  pas_area #(.COORD_BITS(COORD_BITS)) u_area (
    .clk(clk), .xa(xa_r), .ya(ya_r), .xb(xb_r), .yb(yb_r), .xc(x_rd), .yc(y_rd),
    .area(tri_area)
  );

  assign tri_max = (tri_area < acur) ? acur : tri_area;
  assign par_idx = (hi - IDX_W'(1)) >> 1;
  assign lch = CHW'({hi, 1'b1});
  assign rch = CHW'({hi, 1'b0}) + CHW'(2);
  assign l_ok = lch < CHW'(hcount);
  assign r_ok = rch < CHW'(hcount);
  assign end_pt = (i_r == '0) || (i_r == n_r - CW'(1));
  assign out_load = !m_tvalid || m_tready;
  assign last_k = (k_r == n_r - CW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pas_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd_ready = 1'b0;
    run_done = 1'b0;
    xy_raddr = ta;
    a_we = 1'b0;
    a_waddr = upd_pt;
    a_wdata = new_area;
    a_raddr = cur;
    hs_we = 1'b0;
    hs_waddr = hi;
    hs_wdata = obj;
    hs_raddr = '0;
    hp_we = 1'b0;
    hp_waddr = obj;
    hp_wdata = hi;
    hp_raddr = upd_pt;
    pr_we = 1'b0;
    pr_waddr = nx;
    pr_wdata = {1'b0, pv};
    pr_raddr = cur;
    nl_we = 1'b0;
    nl_waddr = pv;
    nl_wdata = {1'b0, nx};
    nl_raddr = cur;
    case (state)
      pas_pkg::BK_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          if ((thr == '0) || (cmd.count < CW'(3))) begin
            state_next = pas_pkg::BK_EMIT;
          end else begin
            state_next = pas_pkg::BK_INIT;
          end
        end
      end
      pas_pkg::BK_INIT: begin
        pr_we = 1'b1;
        pr_waddr = i_r[IDX_W-1:0];
        pr_wdata = (i_r == '0) ? LINK_NIL : LNK_W'(i_r - CW'(1));
        nl_we = 1'b1;
        nl_waddr = i_r[IDX_W-1:0];
        nl_wdata = (i_r == n_r - CW'(1)) ? LINK_NIL : LNK_W'(i_r + CW'(1));
        state_next = end_pt ? pas_pkg::BK_PUSH : pas_pkg::BK_TRI0;
      end
      pas_pkg::BK_TRI0: begin
        xy_raddr = ta;
        state_next = pas_pkg::BK_TRI1;
      end
      pas_pkg::BK_TRI1: begin
        xy_raddr = tb;
        state_next = pas_pkg::BK_TRI2;
      end
      pas_pkg::BK_TRI2: begin
        xy_raddr = tc;
        state_next = pas_pkg::BK_TRI3;
      end
      pas_pkg::BK_TRI3: begin
        state_next = pas_pkg::BK_TRI4;
      end
      pas_pkg::BK_TRI4: begin
        state_next = pas_pkg::BK_TRI5;
      end
      pas_pkg::BK_TRI5: begin
        if (tri_ret == pas_pkg::TR_INIT) begin
          state_next = pas_pkg::BK_PUSH;
        end else begin
          state_next = pas_pkg::BK_UPD0;
        end
      end
      pas_pkg::BK_PUSH: begin
        a_we = 1'b1;
        a_waddr = i_r[IDX_W-1:0];
        a_wdata = new_area;
        state_next = pas_pkg::BK_SU0;
      end
      pas_pkg::BK_SU0: begin
        hs_raddr = par_idx;
        state_next = (hi == '0) ? pas_pkg::BK_SUEND : pas_pkg::BK_SU1;
      end
      pas_pkg::BK_SU1: begin
        a_raddr = hs_rd;
        state_next = pas_pkg::BK_SU2;
      end
      pas_pkg::BK_SU2: begin
        // The parent moves down when its area is strictly greater.
        if (a_rd <= aobj) begin
          state_next = pas_pkg::BK_SUEND;
        end else begin
          hs_we = 1'b1;
          hs_waddr = hi;
          hs_wdata = slot_r;
          hp_we = 1'b1;
          hp_waddr = slot_r;
          hp_wdata = hi;
          state_next = pas_pkg::BK_SU0;
        end
      end
      pas_pkg::BK_SD0: begin
        hs_raddr = lch[IDX_W-1:0];
        state_next = l_ok ? pas_pkg::BK_SD1 : pas_pkg::BK_SDEND;
      end
      pas_pkg::BK_SD1: begin
        a_raddr = hs_rd;
        state_next = pas_pkg::BK_SD2;
      end
      pas_pkg::BK_SD2: begin
        hs_raddr = rch[IDX_W-1:0];
        state_next = r_ok ? pas_pkg::BK_SD3 : pas_pkg::BK_SD5;
      end
      pas_pkg::BK_SD3: begin
        a_raddr = hs_rd;
        state_next = pas_pkg::BK_SD4;
      end
      pas_pkg::BK_SD4: begin
        state_next = pas_pkg::BK_SD5;
      end
      pas_pkg::BK_SD5: begin
        if (dpick == hi) begin
          state_next = pas_pkg::BK_SDEND;
        end else begin
          hs_we = 1'b1;
          hs_waddr = hi;
          hs_wdata = cpick;
          hp_we = 1'b1;
          hp_waddr = cpick;
          hp_wdata = hi;
          state_next = pas_pkg::BK_SD0;
        end
      end
      pas_pkg::BK_SUEND, pas_pkg::BK_SDEND: begin
        hs_we = 1'b1;
        hs_waddr = hi;
        hs_wdata = obj;
        hp_we = 1'b1;
        hp_waddr = obj;
        hp_wdata = hi;
        case (sift_ret)
          pas_pkg::SR_PUSH: begin
            state_next = (i_r == n_r - CW'(1)) ? pas_pkg::BK_POP0 : pas_pkg::BK_INIT;
          end
          pas_pkg::SR_POP: state_next = pas_pkg::BK_CHK0;
          pas_pkg::SR_PREV: state_next = pas_pkg::BK_NXT;
          default: state_next = pas_pkg::BK_POP0;
        endcase
      end
      pas_pkg::BK_POP0: begin
        hs_raddr = '0;
        state_next = (hcount == '0) ? pas_pkg::BK_EMIT : pas_pkg::BK_POP1;
      end
      pas_pkg::BK_POP1: begin
        hs_raddr = IDX_W'(hcount - CW'(1));
        state_next = pas_pkg::BK_POP2;
      end
      pas_pkg::BK_POP2: begin
        a_raddr = hs_rd;
        state_next = pas_pkg::BK_POP3;
      end
      pas_pkg::BK_POP3: begin
        state_next = (hcount != '0) ? pas_pkg::BK_SD0 : pas_pkg::BK_CHK0;
      end
      pas_pkg::BK_CHK0: begin
        a_raddr = cur;
        pr_raddr = cur;
        nl_raddr = cur;
        state_next = pas_pkg::BK_CHK1;
      end
      pas_pkg::BK_CHK1: begin
        if ((CMPW'(a_rd) > CMPW'(thr)) || pr_rd[IDX_W] || nl_rd[IDX_W]) begin
          state_next = pas_pkg::BK_EMIT;
        end else begin
          state_next = pas_pkg::BK_CHK2;
        end
      end
      pas_pkg::BK_CHK2: begin
        nl_we = 1'b1;
        nl_waddr = pv;
        nl_wdata = {1'b0, nx};
        pr_we = 1'b1;
        pr_waddr = nx;
        pr_wdata = {1'b0, pv};
        state_next = pas_pkg::BK_CHK3;
      end
      pas_pkg::BK_CHK3: begin
        pr_raddr = pv;
        nl_raddr = nx;
        state_next = pas_pkg::BK_CHK4;
      end
      pas_pkg::BK_CHK4: begin
        state_next = pr_rd[IDX_W] ? pas_pkg::BK_NXT : pas_pkg::BK_TRI0;
      end
      pas_pkg::BK_NXT: begin
        state_next = nnx[IDX_W] ? pas_pkg::BK_POP0 : pas_pkg::BK_TRI0;
      end
      pas_pkg::BK_UPD0: begin
        a_raddr = upd_pt;
        hp_raddr = upd_pt;
        state_next = pas_pkg::BK_UPD1;
      end
      pas_pkg::BK_UPD1: begin
        a_we = 1'b1;
        a_waddr = upd_pt;
        a_wdata = new_area;
        state_next = (a_rd > new_area) ? pas_pkg::BK_SU0 : pas_pkg::BK_SD0;
      end
      pas_pkg::BK_EMIT: begin
        if (n_r == '0) begin
          state_next = pas_pkg::BK_DONE;
        end else if (out_load && last_k) begin
          state_next = pas_pkg::BK_DONE;
        end
      end
      pas_pkg::BK_DONE: begin
        run_done = 1'b1;
        state_next = pas_pkg::BK_IDLE;
      end
      default: state_next = pas_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      hcount <= '0;
      gone <= '0;
    end else begin
      if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        pas_pkg::BK_IDLE: begin
          if (cmd_valid) begin
            n_r <= cmd.count;
            ovf_r <= cmd.ovf;
            plain_r <= (thr == '0) || (cmd.count < CW'(3));
            i_r <= '0;
            k_r <= '0;
            hcount <= '0;
            gone <= '0;
          end
        end
        pas_pkg::BK_INIT: begin
          if (end_pt) begin
            new_area <= '1;
          end else begin
            ta <= IDX_W'(i_r - CW'(1));
            tb <= i_r[IDX_W-1:0];
            tc <= IDX_W'(i_r + CW'(1));
            tri_ret <= pas_pkg::TR_INIT;
          end
        end
        pas_pkg::BK_TRI1: begin
          xa_r <= x_rd;
          ya_r <= y_rd;
        end
        pas_pkg::BK_TRI2: begin
          xb_r <= x_rd;
          yb_r <= y_rd;
        end
        pas_pkg::BK_TRI5: begin
          case (tri_ret)
            pas_pkg::TR_INIT: new_area <= tri_area;
            pas_pkg::TR_PREV: begin
              new_area <= tri_max;
              upd_pt <= pv;
              sift_ret <= pas_pkg::SR_PREV;
            end
            default: begin
              new_area <= tri_max;
              upd_pt <= nx;
              sift_ret <= pas_pkg::SR_NEXT;
            end
          endcase
        end
        pas_pkg::BK_PUSH: begin
          obj <= i_r[IDX_W-1:0];
          aobj <= new_area;
          hi <= hcount[IDX_W-1:0];
          hcount <= hcount + CW'(1);
          sift_ret <= pas_pkg::SR_PUSH;
        end
        pas_pkg::BK_SU1: begin
          slot_r <= hs_rd;
        end
        pas_pkg::BK_SU2: begin
          if (a_rd > aobj) begin
            hi <= par_idx;
          end
        end
        pas_pkg::BK_SD0: begin
          dpick <= hi;
          cpick <= obj;
          apick <= aobj;
        end
        pas_pkg::BK_SD1, pas_pkg::BK_SD3: begin
          slot_r <= hs_rd;
        end
        pas_pkg::BK_SD2: begin
          if (a_rd < apick) begin
            dpick <= lch[IDX_W-1:0];
            cpick <= slot_r;
            apick <= a_rd;
          end
        end
        pas_pkg::BK_SD4: begin
          if (a_rd < apick) begin
            dpick <= rch[IDX_W-1:0];
            cpick <= slot_r;
            apick <= a_rd;
          end
        end
        pas_pkg::BK_SD5: begin
          if (dpick != hi) begin
            hi <= dpick;
          end
        end
        pas_pkg::BK_SUEND, pas_pkg::BK_SDEND: begin
          if (sift_ret == pas_pkg::SR_PUSH) begin
            i_r <= i_r + CW'(1);
          end
        end
        pas_pkg::BK_POP1: begin
          cur <= hs_rd;
        end
        pas_pkg::BK_POP2: begin
          obj <= hs_rd;
          hcount <= hcount - CW'(1);
        end
        pas_pkg::BK_POP3: begin
          aobj <= a_rd;
          hi <= '0;
          sift_ret <= pas_pkg::SR_POP;
        end
        pas_pkg::BK_CHK1: begin
          acur <= a_rd;
          pv <= pr_rd[IDX_W-1:0];
          nx <= nl_rd[IDX_W-1:0];
        end
        pas_pkg::BK_CHK2: begin
          gone[cur] <= 1'b1;
        end
        pas_pkg::BK_CHK4: begin
          nnx <= nl_rd;
          ta <= pr_rd[IDX_W-1:0];
          tb <= pv;
          tc <= nx;
          tri_ret <= pas_pkg::TR_PREV;
        end
        pas_pkg::BK_NXT: begin
          ta <= pv;
          tb <= nx;
          tc <= nnx[IDX_W-1:0];
          tri_ret <= pas_pkg::TR_NEXT;
        end
        pas_pkg::BK_UPD1: begin
          hi <= hp_rd;
          obj <= upd_pt;
          aobj <= new_area;
        end
        pas_pkg::BK_EMIT: begin
          if ((n_r != '0) && out_load) begin
            m_tvalid <= 1'b1;
            m_tdata <= {2'b00, k_r[pas_pkg::IDX_OUT_W-1:0]};
            m_tuser <= {ovf_r, plain_r, plain_r || !gone[k_r[IDX_W-1:0]]};
            m_tlast <= last_k;
            k_r <= k_r + CW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  `PAS_ASSERT(a_heap_bound, (state == pas_pkg::BK_IDLE) || (hcount <= n_r), "heap larger than the run")
  `PAS_ASSERT(a_first_kept, !gone[0], "first point was removed")
  `PAS_ASSERT_NEXT(a_last_done, (state == pas_pkg::BK_EMIT) && out_load && last_k && (n_r != '0), m_tvalid && m_tlast && (state == pas_pkg::BK_DONE), "final result not closing the run")

endmodule

### hdl/polyline_area_simplifier.sv
// Points load one per cycle unless a run is outstanding and the loader is locked.
// Each heap level of a sift reads the slot and area RAMs in turn through their single read ports.
// Each triangle area takes three store reads and the two-stage multiplier.
// Results leave the output register one per cycle when not stalled; next polyline loads after.
// Reset is synchronous and active high; it clears the control state and the threshold.
// The point and heap stores need no clearing pass, a run reads only what it wrote.
module polyline_area_simplifier #(
  parameter int MAX_POINTS = 64,
  parameter int COORD_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_wr_en,
  input  logic [pas_pkg::THR_W-1:0]              cfg_wr_data,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // x_coord, y_coord
  input  logic [((2*COORD_BITS+7)/8)*8-1:0]      s_tdata,
  input  logic                                   s_tlast,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // point_index
  output logic [7:0]                             m_tdata,
  // keep, not_simplified, overflow
  output logic [2:0]                             m_tuser,
  output logic                                   m_tlast
);

  localparam int IDX_W = $clog2(MAX_POINTS);

  logic [pas_pkg::THR_W-1:0] area_threshold;
  logic                      wr_en;
  logic [IDX_W-1:0]          wr_addr;
  logic [COORD_BITS-1:0]     wr_x;
  logic [COORD_BITS-1:0]     wr_y;
  logic [IDX_W-1:0]          xy_raddr;
  logic [COORD_BITS-1:0]     x_rd;
  logic [COORD_BITS-1:0]     y_rd;
  logic                      push_valid;
  pas_pkg::run_cmd_t         push_cmd;
  logic                      pop_valid;
  logic                      pop_ready;
  pas_pkg::run_cmd_t         pop_cmd;
  logic                      run_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      area_threshold <= '0;
    end else if (cfg_wr_en) begin
      area_threshold <= cfg_wr_data;
    end
  end

  pas_front #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_front (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .wr_en(wr_en), .wr_addr(wr_addr), .wr_x(wr_x), .wr_y(wr_y),
    .cmd_valid(push_valid), .cmd(push_cmd), .run_done(run_done)
  );

  pas_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_POINTS)) u_x_ram (
    .clk(clk), .we(wr_en), .waddr(wr_addr), .wdata(wr_x), .raddr(xy_raddr), .rdata(x_rd)
  );

  pas_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_POINTS)) u_y_ram (
    .clk(clk), .we(wr_en), .waddr(wr_addr), .wdata(wr_y), .raddr(xy_raddr), .rdata(y_rd)
  );

  pas_cmd_fifo u_cmd_fifo (
    .clk(clk), .rst(rst),
    .wr_valid(push_valid), .wr_data(push_cmd),
    .rd_valid(pop_valid), .rd_ready(pop_ready), .rd_data(pop_cmd)
  );

  pas_back #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_back (
    .clk(clk), .rst(rst), .thr(area_threshold),
    .cmd_valid(pop_valid), .cmd_ready(pop_ready), .cmd(pop_cmd), .run_done(run_done),
    .xy_raddr(xy_raddr), .x_rd(x_rd), .y_rd(y_rd),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

endmodule

### test/tb_polyline_area_simplifier.sv
// Self-checking testbench for the polyline area simplifier stream block.
module tb_polyline_area_simplifier;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NPTS = 64;
  localparam int WATCH_LIMIT = 200000;
  localparam logic [33:0] AREA_MAX = '1;

  typedef struct packed {
    logic [5:0] index;
    logic       keep;
    logic       plain;
    logic       ovf;
    logic       last;
  } flag_t;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [32:0] cfg_wr_data;
  logic s_tvalid;
  logic s_tready;
  logic [31:0] s_tdata;
  logic s_tlast;
  logic m_tvalid;
  logic m_tready;
  logic [7:0] m_tdata;
  logic [2:0] m_tuser;
  logic m_tlast;

  polyline_area_simplifier u_dut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast)
  );

  // Predictor state.
  logic signed [15:0] px[NPTS];
  logic signed [15:0] py[NPTS];
  int prv[NPTS];
  int nxt[NPTS];
  logic [33:0] parea[NPTS];
  int hslot[NPTS];
  int hpos[NPTS];
  int hcnt;
  int npts;
  bit dropped;
  logic [32:0] thresh;

  flag_t flags_due[$];
  int errors = 0;
  int idle_cycles = 0;
  int sink_wait = 0;
  bit hold_sink = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic logic [33:0] tri2(int a, int b, int c);
    longint dx1, dy1, dx2, dy2, v;
    dx1 = px[b] - px[a];
    dy1 = py[b] - py[a];
    dx2 = px[c] - px[a];
    dy2 = py[c] - py[a];
    v = dx1 * dy2 - dy1 * dx2;
    if (v < 0) v = -v;
    return v[33:0];
  endfunction

  function automatic void hswap(int i, int j);
    int t;
    t = hslot[i];
    hslot[i] = hslot[j];
    hslot[j] = t;
    hpos[hslot[i]] = i;
    hpos[hslot[j]] = j;
  endfunction

  function automatic void heap_rise(int i);
    int p;
    while (i > 0) begin
      p = (i + 1) / 2 - 1;
      if (parea[hslot[p]] <= parea[hslot[i]]) break;
      hswap(i, p);
      i = p;
    end
  endfunction

  function automatic void heap_sink(int i);
    int l, r, d;
    forever begin
      r = (i + 1) * 2;
      l = r - 1;
      d = i;
      if (l < hcnt && parea[hslot[l]] < parea[hslot[d]]) d = l;
      if (r < hcnt && parea[hslot[r]] < parea[hslot[d]]) d = r;
      if (d == i) break;
      hswap(i, d);
      i = d;
    end
  endfunction

  function automatic void heap_set(int p, logic [33:0] a);
    bit lower;
    lower = parea[p] > a;
    parea[p] = a;
    if (lower) heap_rise(hpos[p]);
    else heap_sink(hpos[p]);
  endfunction

  function automatic void run_simplify(int n);
    int cur, pv, nx;
    logic [33:0] a;
    hcnt = 0;
    for (int i = 0; i < n; i++) begin
      prv[i] = (i == 0) ? -1 : i - 1;
      nxt[i] = (i + 1 == n) ? -1 : i + 1;
      parea[i] = (i == 0 || i + 1 == n) ? AREA_MAX : tri2(i - 1, i, i + 1);
      hslot[hcnt] = i;
      hpos[i] = hcnt;
      hcnt++;
      heap_rise(hcnt - 1);
    end
    while (hcnt > 0) begin
      cur = hslot[0];
      hcnt--;
      if (hcnt > 0) begin
        hslot[0] = hslot[hcnt];
        hpos[hslot[0]] = 0;
        heap_sink(0);
      end
      if (parea[cur] > {1'b0, thresh}) break;
      pv = prv[cur];
      nx = nxt[cur];
      if (pv < 0 || nx < 0) break;
      nxt[pv] = nx;
      prv[nx] = pv;
      if (prv[pv] >= 0) begin
        a = tri2(prv[pv], pv, nx);
        if (a < parea[cur]) a = parea[cur];
        heap_set(pv, a);
      end
      if (nxt[nx] >= 0) begin
        a = tri2(pv, nx, nxt[nx]);
        if (a < parea[cur]) a = parea[cur];
        heap_set(nx, a);
      end
    end
  endfunction

  // Updates the predictor with one accepted point and, on the final one, queues the polyline's flags.
  function automatic void predict_point(logic [15:0] x, logic [15:0] y, bit fin);
    bit plain;
    bit kept[NPTS];
    int p;
    flag_t f;
    if (npts < NPTS) begin
      px[npts] = x;
      py[npts] = y;
      npts++;
    end else begin
      dropped = 1;
    end
    if (!fin) return;
    plain = (thresh == 0) || (npts < 3);
    for (int k = 0; k < NPTS; k++) kept[k] = plain;
    if (!plain) begin
      run_simplify(npts);
      p = 0;
      while (p >= 0) begin
        kept[p] = 1;
        p = nxt[p];
      end
    end
    for (int k = 0; k < npts; k++) begin
      f.index = k[5:0];
      f.keep = kept[k];
      f.plain = plain;
      f.ovf = dropped;
      f.last = (k + 1 == npts);
      flags_due = {flags_due, f};
    end
    npts = 0;
    dropped = 0;
  endfunction

  // Leaves tvalid high after the transfer; stop_source ends a burst.
  task automatic send_point(logic [15:0] x, logic [15:0] y, bit fin, bit gaps = 1);
    int gap;
    if (gaps && $urandom_range(0, 3) == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {y, x};
    s_tlast <= fin;
    do @(posedge clk); while (!s_tready);
    predict_point(x, y, fin);
  endtask

  task automatic stop_source();
    s_tvalid <= 0;
  endtask

  task automatic wait_drained();
    while (flags_due.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic set_threshold(logic [32:0] v);
    cfg_wr_en <= 1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 0;
    thresh = v;
  endtask

  task automatic send_line(int n, int span, bit gaps = 1);
    for (int i = 0; i < n; i++)
      send_point(16'($urandom_range(0, span) - span / 2),
                 16'($urandom_range(0, span) - span / 2), i == n - 1, gaps);
  endtask

  // Sink: random stalls, mostly short with a few long ones, and an optional hold-off.
  always @(posedge clk) begin
    if (rst || hold_sink) begin
      m_tready <= 0;
    end else if (sink_wait > 0) begin
      m_tready <= 0;
      sink_wait <= sink_wait - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      m_tready <= 0;
      sink_wait <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    end else begin
      m_tready <= 1;
    end
  end

  always @(posedge clk) begin
    flag_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[5:0], m_tuser[0], m_tuser[1], m_tuser[2], m_tlast};
      if (flags_due.size() == 0) begin
        $display("%0t: unexpected result, actual %p", $time, got);
        errors++;
      end else begin
        want = flags_due.pop_front();
        if (got !== want || m_tdata[7:6] !== 2'b00) begin
          $display("%0t: result mismatch, expected %p, actual %p (tdata %h)",
                   $time, want, got, m_tdata);
          errors++;
        end
      end
    end
  end

  // Watchdog on transfer activity.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic test_plain();
    set_threshold(33'd0);
    send_line(5, 200);
    send_point(16'h8000, 16'h7FFF, 1);
    send_point(16'h7FFF, 16'h8000, 0);
    send_point(16'h0000, 16'hFFFF, 1);
    stop_source();
    wait_drained();
  endtask

  task automatic test_directed();
    set_threshold(33'h1_FFFF_FFFF);
    // Extreme corners and a colinear run: everything interior goes; the zigzag keeps its points.
    send_point(16'h8000, 16'h8000, 0);
    send_point(16'h7FFF, 16'h7FFF, 0);
    send_point(16'h8000, 16'h7FFF, 0);
    send_point(16'h7FFF, 16'h8000, 1);
    stop_source();
    wait_drained();
    set_threshold(33'd1);
    for (int i = 0; i < 6; i++) send_point(16'(i), (i % 2) ? 16'd1 : 16'd0, i == 5);
    for (int i = 0; i < 5; i++) send_point(16'(i * 3), 16'd7, i == 4);
    stop_source();
    wait_drained();
  endtask

  task automatic test_overflow();
    set_threshold(33'd500);
    send_line(NPTS + 3, 40, 0);
    stop_source();
    wait_drained();
    set_threshold(33'h1_0000_0000);
    send_line(NPTS, 30000, 0);
    stop_source();
    wait_drained();
  endtask

  task automatic test_random();
    int sent, n;
    logic [32:0] th[4] = '{33'd1, 33'd300, 33'd40000, 33'h1_FFFF_FFFF};
    sent = 0;
    while (sent < 20) begin
      set_threshold(th[$urandom_range(0, 3)] +
                    33'($urandom_range(0, 3) * $urandom_range(0, 50)));
      for (int r = 0; r < 4; r++) begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 16);
        send_line(n, ($urandom_range(0, 3) == 0) ? 65535 : 60);
        sent += n;
      end
      stop_source();
      wait_drained();
    end
  endtask

  task automatic test_backpressure();
    set_threshold(33'd100);
    fork
      begin
        hold_sink = 1;
        repeat (400) @(posedge clk);
        hold_sink = 0;
      end
      begin
        for (int r = 0; r < 3; r++) send_line(10, 50, 0);
        stop_source();
      end
    join
    wait_drained();
  endtask

  initial begin
    rst = 1;
    cfg_wr_en = 0;
    cfg_wr_data = 0;
    s_tvalid = 0;
    s_tdata = 0;
    s_tlast = 0;
    npts = 0;
    dropped = 0;
    hcnt = 0;
    thresh = 0;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_plain();
    test_directed();
    test_overflow();
    test_backpressure();
    test_random();
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

### sim.f
+incdir+hdl
hdl/pas_pkg.sv
hdl/pas_ram.sv
hdl/pas_cmd_fifo.sv
hdl/pas_front.sv
hdl/pas_area.sv
hdl/pas_back.sv
hdl/polyline_area_simplifier.sv
test/tb_polyline_area_simplifier.sv
